### hw/rtl/uniform_grid_neighbor_binning_defines.svh
// Assertion macros used by the grid binning back end.
// No dependencies; expects clk and arst_n in the including scope.
`ifndef UNIFORM_GRID_NEIGHBOR_BINNING_DEFINES_SVH
`define UNIFORM_GRID_NEIGHBOR_BINNING_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define UGNB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define UGNB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/ugnb_pkg.sv
// Shared types and constants for the uniform grid binning block.
// No dependencies.
`timescale 1ns / 1ps

package ugnb_pkg;
	localparam int GRID_W = 32;
	localparam int GRID_H = 32;
	localparam int CELL_CAP = 4;
	localparam int CELLS = GRID_W * GRID_H;
	localparam int SLOTS = CELLS * CELL_CAP;
	localparam int CELL_W = $clog2(CELLS);
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CX_W = $clog2(GRID_W);
	localparam int CY_W = $clog2(GRID_H);
	localparam int DIV_STEPS = (CX_W > CY_W) ? CX_W : CY_W;
	localparam int STEP_W = $clog2(DIV_STEPS + 1);
	localparam int FILL_W = 3;
	localparam int ID_W = 16;
	localparam int DIM_W = 6;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NOP = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_OUT = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_NEIGHBOR = 3'd3;
	localparam logic [2:0] ST_NONE = 3'd4;

	localparam logic [2:0] REG_GRID_W = 3'd0;
	localparam logic [2:0] REG_GRID_H = 3'd1;
	localparam logic [2:0] REG_CELL_SIZE = 3'd2;
	localparam logic [2:0] REG_OFFSET_X = 3'd3;
	localparam logic [2:0] REG_OFFSET_Y = 3'd4;

	typedef struct packed {
		logic [1:0] op;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [ID_W-1:0] particle_id;
	} in_t;

	typedef struct packed {
		logic [ID_W-1:0] found_id;
		logic [2:0] status;
		logic last;
	} out_t;

	typedef struct packed {
		logic [1:0] op;
		logic off;
		logic [CX_W-1:0] cx;
		logic [CY_W-1:0] cy;
		logic [ID_W-1:0] id;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} cmd_t;
endpackage

### hw/rtl/ugnb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ugnb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/ugnb_cmdq.sv
// Two-entry command queue between the binning front and the cell back end.
// Depends on ugnb_pkg.
`timescale 1ns / 1ps

module ugnb_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  ugnb_pkg::cmd_t wdata,
	input  logic           pop,
	output logic           empty,
	output ugnb_pkg::cmd_t rdata
);
	ugnb_pkg::cmd_t ent_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = ent_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= wdata;
		end
	end
endmodule

### hw/rtl/ugnb_front.sv
// Front end: accepts items, bins positions by restoring division, queues commands.
// Depends on ugnb_pkg.
`timescale 1ns / 1ps

module ugnb_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  ugnb_pkg::in_t                in_item,
	input  logic [ugnb_pkg::DIM_W-1:0]   grid_width,
	input  logic [ugnb_pkg::DIM_W-1:0]   grid_height,
	input  logic [30:0]                  cell_size,
	input  logic [31:0]                  offset_x,
	input  logic [31:0]                  offset_y,
	input  logic                         init_busy,
	input  logic                         cq_full,
	output logic                         cq_push,
	output ugnb_pkg::cmd_t               cq_data
);
	localparam int DV_W = 32 + ugnb_pkg::DIV_STEPS + 1;

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_SEND} fstate_t;

	fstate_t                         state_q;
	logic [1:0]                      op_q;
	logic [ugnb_pkg::ID_W-1:0]       id_q;
	logic [31:0]                     remx_q;
	logic [31:0]                     remy_q;
	logic [ugnb_pkg::DIV_STEPS-1:0]  qx_q;
	logic [ugnb_pkg::DIV_STEPS-1:0]  qy_q;
	logic                            offx_q;
	logic                            offy_q;
	logic [ugnb_pkg::STEP_W-1:0]     step_q;

	logic                            accept;
	logic signed [32:0]              sum_x;
	logic signed [32:0]              sum_y;
	logic [DV_W-1:0]                 dv;
	logic                            gex;
	logic                            gey;
	logic [ugnb_pkg::DIM_W-1:0]      used_w;
	logic [ugnb_pkg::DIM_W-1:0]      used_h;
	logic [ugnb_pkg::DIV_STEPS-1:0]  qbit;

	assign full = (state_q != F_IDLE) || init_busy;
	assign accept = push && !full;
	assign sum_x = {in_item.pos_x[31], in_item.pos_x} + {offset_x[31], offset_x};
	assign sum_y = {in_item.pos_y[31], in_item.pos_y} + {offset_y[31], offset_y};
	assign dv = {{(DV_W-31){1'b0}}, cell_size} << step_q;
	assign gex = {{(DV_W-32){1'b0}}, remx_q} >= dv;
	assign gey = {{(DV_W-32){1'b0}}, remy_q} >= dv;
	assign qbit = ugnb_pkg::DIV_STEPS'(1) << step_q;
	assign used_w = (int'(grid_width) > ugnb_pkg::GRID_W) ?
		ugnb_pkg::DIM_W'(ugnb_pkg::GRID_W) : grid_width;
	assign used_h = (int'(grid_height) > ugnb_pkg::GRID_H) ?
		ugnb_pkg::DIM_W'(ugnb_pkg::GRID_H) : grid_height;

	assign cq_push = (state_q == F_SEND) && !cq_full;

	always_comb begin
		cq_data.op = op_q;
		cq_data.off = offx_q || offy_q ||
			(ugnb_pkg::DIM_W'(qx_q) >= used_w) || (ugnb_pkg::DIM_W'(qy_q) >= used_h);
		cq_data.cx = qx_q[ugnb_pkg::CX_W-1:0];
		cq_data.cy = qy_q[ugnb_pkg::CY_W-1:0];
		cq_data.id = id_q;
		cq_data.w = used_w;
		cq_data.h = used_h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			op_q <= ugnb_pkg::OP_NOP;
			id_q <= '0;
			remx_q <= '0;
			remy_q <= '0;
			qx_q <= '0;
			qy_q <= '0;
			offx_q <= 1'b0;
			offy_q <= 1'b0;
			step_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						op_q <= in_item.op;
						id_q <= in_item.particle_id;
						remx_q <= sum_x[31:0];
						remy_q <= sum_y[31:0];
						qx_q <= '0;
						qy_q <= '0;
						offx_q <= sum_x[32] || (cell_size == 31'd0);
						offy_q <= sum_y[32] || (cell_size == 31'd0);
						step_q <= ugnb_pkg::STEP_W'(ugnb_pkg::DIV_STEPS);
						if (in_item.op == ugnb_pkg::OP_CLEAR) begin
							state_q <= F_SEND;
						end else if (in_item.op != ugnb_pkg::OP_NOP) begin
							state_q <= F_DIV;
						end
					end
				end
				F_DIV: begin
					if (gex) begin
						remx_q <= remx_q - dv[31:0];
						if (step_q == ugnb_pkg::STEP_W'(ugnb_pkg::DIV_STEPS)) begin
							offx_q <= 1'b1;
						end else begin
							qx_q <= qx_q | qbit;
						end
					end
					if (gey) begin
						remy_q <= remy_q - dv[31:0];
						if (step_q == ugnb_pkg::STEP_W'(ugnb_pkg::DIV_STEPS)) begin
							offy_q <= 1'b1;
						end else begin
							qy_q <= qy_q | qbit;
						end
					end
					if (step_q == '0) begin
						state_q <= F_SEND;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				F_SEND: begin
					if (!cq_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end
endmodule

### hw/rtl/ugnb_back.sv
// Back end: cell fill and id stores, insert, clear sweep, neighbour walk, result queue.
// Depends on ugnb_pkg, ugnb_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "uniform_grid_neighbor_binning_defines.svh"

module ugnb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cq_empty,
	input  ugnb_pkg::cmd_t cq_data,
	output logic           cq_pop,
	output logic           init_busy,
	output logic           empty,
	input  logic           pop,
	output ugnb_pkg::out_t out_item
);
	localparam int NX_W = ugnb_pkg::CX_W + 2;
	localparam int NY_W = ugnb_pkg::CY_W + 2;

	typedef enum logic [3:0] {
		B_INIT, B_IDLE, B_INS_RD, B_INS_DEC, B_CLR,
		B_Q_CELL, B_Q_FILL, B_Q_ENT, B_Q_END, B_PUSH
	} bstate_t;

	bstate_t                         state_q;
	ugnb_pkg::cmd_t                  cmd_q;
	logic [ugnb_pkg::CELL_W-1:0]     sweep_q;
	logic [1:0]                      dx_q;
	logic [1:0]                      dy_q;
	logic [ugnb_pkg::FILL_W-1:0]     fill_q;
	logic [ugnb_pkg::FILL_W-1:0]     k_q;
	logic [ugnb_pkg::ID_W-1:0]       held_q;
	logic                            held_v_q;
	ugnb_pkg::out_t                  res_q;
	logic                            valid_s1;
	ugnb_pkg::out_t                  ob_q [2];
	logic                            wr_q;
	logic                            rd_q;
	logic [1:0]                      cnt_q;

	logic [NX_W-1:0]                 nx;
	logic [NY_W-1:0]                 ny;
	logic                            nb_in;
	logic                            nb_last;
	logic [ugnb_pkg::CELL_W-1:0]     nb_cell;
	logic [ugnb_pkg::CELL_W-1:0]     ins_cell;
	logic                            fill_we;
	logic [ugnb_pkg::CELL_W-1:0]     fill_waddr;
	logic [ugnb_pkg::FILL_W-1:0]     fill_wdata;
	logic [ugnb_pkg::CELL_W-1:0]     fill_raddr;
	logic [ugnb_pkg::FILL_W-1:0]     fill_rdata;
	logic                            store_we;
	logic [ugnb_pkg::SLOT_W-1:0]     store_waddr;
	logic [ugnb_pkg::SLOT_W-1:0]     store_raddr;
	logic [ugnb_pkg::ID_W-1:0]       store_rdata;
	logic                            ins_full;
	logic                            space_ok;
	logic                            issue;
	logic                            push_en;
	ugnb_pkg::out_t                  push_data;
	logic                            pop_en;

	assign init_busy = state_q == B_INIT;
	assign cq_pop = (state_q == B_IDLE) && !cq_empty;

	assign nx = NX_W'(cmd_q.cx) + NX_W'(dx_q) - NX_W'(1);
	assign ny = NY_W'(cmd_q.cy) + NY_W'(dy_q) - NY_W'(1);
	assign nb_in = (NX_W'(nx) < NX_W'(cmd_q.w)) && (NY_W'(ny) < NY_W'(cmd_q.h));
	assign nb_last = (dx_q == 2'd2) && (dy_q == 2'd2);
	assign nb_cell = ugnb_pkg::CELL_W'(nx[ugnb_pkg::CX_W-1:0]) *
		ugnb_pkg::CELL_W'(ugnb_pkg::GRID_H) + ugnb_pkg::CELL_W'(ny[ugnb_pkg::CY_W-1:0]);
	assign ins_cell = ugnb_pkg::CELL_W'(cmd_q.cx) *
		ugnb_pkg::CELL_W'(ugnb_pkg::GRID_H) + ugnb_pkg::CELL_W'(cmd_q.cy);

	assign ins_full = fill_rdata >= ugnb_pkg::FILL_W'(ugnb_pkg::CELL_CAP);
	assign fill_raddr = (state_q == B_INS_RD) ? ins_cell : nb_cell;
	assign fill_we = (state_q == B_INIT) || (state_q == B_CLR) ||
		((state_q == B_INS_DEC) && !ins_full);
	assign fill_waddr = (state_q == B_INS_DEC) ? ins_cell : sweep_q;
	assign fill_wdata = (state_q == B_INS_DEC) ? fill_rdata + 1'b1 : '0;

	assign store_we = (state_q == B_INS_DEC) && !ins_full;
	assign store_waddr = ugnb_pkg::SLOT_W'(ins_cell) * ugnb_pkg::SLOT_W'(ugnb_pkg::CELL_CAP) +
		ugnb_pkg::SLOT_W'(fill_rdata);
	assign store_raddr = ugnb_pkg::SLOT_W'(nb_cell) * ugnb_pkg::SLOT_W'(ugnb_pkg::CELL_CAP) +
		ugnb_pkg::SLOT_W'(k_q);

	assign space_ok = ({1'b0, cnt_q} + {2'b0, valid_s1}) <= 3'd1;
	assign issue = (state_q == B_Q_ENT) && (k_q != fill_q) && space_ok;

	always_comb begin
		push_en = 1'b0;
		push_data = res_q;
		if (valid_s1 && held_v_q) begin
			push_en = 1'b1;
			push_data.found_id = held_q;
			push_data.status = ugnb_pkg::ST_NEIGHBOR;
			push_data.last = 1'b0;
		end else if ((state_q == B_PUSH) && (cnt_q != 2'd2)) begin
			push_en = 1'b1;
		end
	end

	assign empty = cnt_q == 2'd0;
	assign out_item = ob_q[rd_q];
	assign pop_en = pop && !empty;

	ugnb_ram #(
		.WIDTH(ugnb_pkg::FILL_W),
		.DEPTH(ugnb_pkg::CELLS)
	) u_fill (
		.clk(clk),
		.we(fill_we),
		.waddr(fill_waddr),
		.wdata(fill_wdata),
		.raddr(fill_raddr),
		.rdata(fill_rdata)
	);

	ugnb_ram #(
		.WIDTH(ugnb_pkg::ID_W),
		.DEPTH(ugnb_pkg::SLOTS)
	) u_store (
		.clk(clk),
		.we(store_we),
		.waddr(store_waddr),
		.wdata(cmd_q.id),
		.raddr(store_raddr),
		.rdata(store_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
			cmd_q <= '0;
			sweep_q <= '0;
			dx_q <= '0;
			dy_q <= '0;
			fill_q <= '0;
			k_q <= '0;
			held_q <= '0;
			held_v_q <= 1'b0;
			res_q <= '0;
			valid_s1 <= 1'b0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			valid_s1 <= issue;
			if (valid_s1) begin
				held_q <= store_rdata;
				held_v_q <= 1'b1;
			end
			if (push_en) begin
				wr_q <= !wr_q;
			end
			if (pop_en) begin
				rd_q <= !rd_q;
			end
			if (push_en && !pop_en) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop_en && !push_en) begin
				cnt_q <= cnt_q - 2'd1;
			end
			case (state_q)
				B_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == ugnb_pkg::CELL_W'(ugnb_pkg::CELLS - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (!cq_empty) begin
						cmd_q <= cq_data;
						sweep_q <= '0;
						dx_q <= '0;
						dy_q <= '0;
						held_v_q <= 1'b0;
						res_q.found_id <= '0;
						res_q.last <= 1'b1;
						case (cq_data.op)
							ugnb_pkg::OP_CLEAR: begin
								state_q <= B_CLR;
							end
							ugnb_pkg::OP_INSERT: begin
								if (cq_data.off) begin
									res_q.status <= ugnb_pkg::ST_OUT;
									state_q <= B_PUSH;
								end else begin
									state_q <= B_INS_RD;
								end
							end
							ugnb_pkg::OP_QUERY: begin
								if (cq_data.off) begin
									res_q.status <= ugnb_pkg::ST_NONE;
									state_q <= B_PUSH;
								end else begin
									state_q <= B_Q_CELL;
								end
							end
							default: begin
								state_q <= B_IDLE;
							end
						endcase
					end
				end
				B_INS_RD: begin
					state_q <= B_INS_DEC;
				end
				B_INS_DEC: begin
					res_q.status <= ins_full ? ugnb_pkg::ST_FULL : ugnb_pkg::ST_OK;
					state_q <= B_PUSH;
				end
				B_CLR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == ugnb_pkg::CELL_W'(ugnb_pkg::CELLS - 1)) begin
						res_q.status <= ugnb_pkg::ST_OK;
						state_q <= B_PUSH;
					end
				end
				B_Q_CELL: begin
					if (nb_in) begin
						state_q <= B_Q_FILL;
					end else if (nb_last) begin
						state_q <= B_Q_END;
					end else if (dy_q == 2'd2) begin
						dy_q <= '0;
						dx_q <= dx_q + 2'd1;
					end else begin
						dy_q <= dy_q + 2'd1;
					end
				end
				B_Q_FILL: begin
					fill_q <= fill_rdata;
					k_q <= '0;
					state_q <= B_Q_ENT;
				end
				B_Q_ENT: begin
					if (k_q == fill_q) begin
						if (nb_last) begin
							state_q <= B_Q_END;
						end else begin
							state_q <= B_Q_CELL;
							if (dy_q == 2'd2) begin
								dy_q <= '0;
								dx_q <= dx_q + 2'd1;
							end else begin
								dy_q <= dy_q + 2'd1;
							end
						end
					end else if (issue) begin
						k_q <= k_q + 1'b1;
					end
				end
				B_Q_END: begin
					if (!valid_s1) begin
						res_q.found_id <= held_v_q ? held_q : '0;
						res_q.status <= held_v_q ? ugnb_pkg::ST_NEIGHBOR : ugnb_pkg::ST_NONE;
						res_q.last <= 1'b1;
						state_q <= B_PUSH;
					end
				end
				B_PUSH: begin
					if (cnt_q != 2'd2) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			ob_q[wr_q] <= push_data;
		end
	end

	`UGNB_ASSERT_NOW(a_no_push_full, push_en, cnt_q != 2'd2, "result pushed into full queue")
	`UGNB_ASSERT_NEXT(a_issue_lands, issue, valid_s1, "store read lost")
	`UGNB_ASSERT_NOW(a_final_drained, state_q == B_PUSH, !valid_s1, "final result before walk drained")
	`UGNB_ASSERT_NOW(a_idle_only_pop, cq_pop, state_q == B_IDLE, "command taken while busy")
endmodule

### hw/rtl/uniform_grid_neighbor_binning.sv
// Uniform grid neighbour binning, top level: config registers, front, queue, back.
// Depends on ugnb_pkg, ugnb_front, ugnb_cmdq, ugnb_back.
`timescale 1ns / 1ps

// Cell-list binning over a 32 x 32 grid of cells, four ids per cell. After reset the
// block clears all 1024 cells of the fill store and holds full high meanwhile. Binning
// in the front is a restoring division, one quotient bit per cycle on both axes at
// once; the back end then reads and bumps the fill count for an insert, sweeps the
// fill memory for a clear (one cell a cycle), and for a query walks the 3 x 3
// neighbouring cells, reading the fill count and then the ids of each cell inside the
// grid and skipping cells outside it; id reads wait for room in the two-entry result
// queue, so the walk runs longer while the result side stalls. The command queue
// lets binning of the next item overlap the back end's work.
module uniform_grid_neighbor_binning (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  ugnb_pkg::in_t  in_item,
	output logic           empty,
	input  logic           pop,
	output ugnb_pkg::out_t out_item,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [4:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	logic [ugnb_pkg::DIM_W-1:0] grid_width_q;
	logic [ugnb_pkg::DIM_W-1:0] grid_height_q;
	logic [30:0]                cell_size_q;
	logic [31:0]                offset_x_q;
	logic [31:0]                offset_y_q;
	logic                       wr_en;
	logic [2:0]                 reg_idx;
	logic                       init_busy;
	logic                       cq_full;
	logic                       cq_push;
	ugnb_pkg::cmd_t             cq_wdata;
	logic                       cq_pop;
	logic                       cq_empty;
	ugnb_pkg::cmd_t             cq_rdata;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	always_comb begin
		case (reg_idx)
			ugnb_pkg::REG_GRID_W: prdata = 32'(grid_width_q);
			ugnb_pkg::REG_GRID_H: prdata = 32'(grid_height_q);
			ugnb_pkg::REG_CELL_SIZE: prdata = 32'(cell_size_q);
			ugnb_pkg::REG_OFFSET_X: prdata = offset_x_q;
			ugnb_pkg::REG_OFFSET_Y: prdata = offset_y_q;
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= ugnb_pkg::DIM_W'(32);
			grid_height_q <= ugnb_pkg::DIM_W'(32);
			cell_size_q <= 31'd65536;
			offset_x_q <= '0;
			offset_y_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				ugnb_pkg::REG_GRID_W: grid_width_q <= pwdata[ugnb_pkg::DIM_W-1:0];
				ugnb_pkg::REG_GRID_H: grid_height_q <= pwdata[ugnb_pkg::DIM_W-1:0];
				ugnb_pkg::REG_CELL_SIZE: cell_size_q <= pwdata[30:0];
				ugnb_pkg::REG_OFFSET_X: offset_x_q <= pwdata;
				ugnb_pkg::REG_OFFSET_Y: offset_y_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	ugnb_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_item(in_item),
		.grid_width(grid_width_q),
		.grid_height(grid_height_q),
		.cell_size(cell_size_q),
		.offset_x(offset_x_q),
		.offset_y(offset_y_q),
		.init_busy(init_busy),
		.cq_full(cq_full),
		.cq_push(cq_push),
		.cq_data(cq_wdata)
	);

	ugnb_cmdq u_cmdq (
		.clk(clk),
		.arst_n(arst_n),
		.push(cq_push),
		.full(cq_full),
		.wdata(cq_wdata),
		.pop(cq_pop),
		.empty(cq_empty),
		.rdata(cq_rdata)
	);

	ugnb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cq_empty(cq_empty),
		.cq_data(cq_rdata),
		.cq_pop(cq_pop),
		.init_busy(init_busy),
		.empty(empty),
		.pop(pop),
		.out_item(out_item)
	);
endmodule
